// ----- rtl/ctpp_pkg.sv -----
package ctpp_pkg;

	// Default tape capacity in bits
	localparam int unsigned TAPE_BITS_DEF = 65536;

	localparam int CFG_W   = 16;
	localparam int STAMP_W = 32;
	localparam int COUNT_W = 17;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_BIT    = 2'd1,
		OP_BYTE   = 2'd2,
		OP_CLEAR  = 2'd3
	} ctpp_op_t;

	typedef enum logic [1:0] {
		CFG_LOW_TIME  = 2'd0,
		CFG_BASE_TIME = 2'd1,
		CFG_ONE_EXTRA = 2'd2,
		CFG_TIMEOUT   = 2'd3
	} ctpp_cfg_idx_t;

	localparam logic [CFG_W-1:0] LOW_TIME_RST  = 16'd120;
	localparam logic [CFG_W-1:0] BASE_TIME_RST = 16'd1250;
	localparam logic [CFG_W-1:0] ONE_EXTRA_RST = 16'd532;
	localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd5040;

	// Append request toward the tape store
	typedef struct packed {
		logic push_bit;
		logic push_byte;
	} ctpp_push_t;

endpackage

// ----- rtl/ctpp_item_if.sv -----
interface ctpp_item_if;
	logic                          valid;
	logic                          ready;
	ctpp_pkg::ctpp_op_t            opcode;
	logic [ctpp_pkg::STAMP_W-1:0]  cycle_stamp;
	logic [7:0]                    data_byte;

	modport source (output valid, output opcode, output cycle_stamp, output data_byte,
		input ready);
	modport sink (input valid, input opcode, input cycle_stamp, input data_byte,
		output ready);
endinterface

// ----- rtl/ctpp_result_if.sv -----
interface ctpp_result_if;
	logic                          valid;
	logic                          ready;
	logic                          tape_level;
	logic                          tape_full;
	logic [ctpp_pkg::COUNT_W-1:0]  bits_stored;

	modport source (output valid, output tape_level, output tape_full, output bits_stored,
		input ready);
	modport sink (input valid, input tape_level, input tape_full, input bits_stored,
		output ready);
endinterface

// ----- rtl/cassette_tape_pulse_player.sv -----
// An accepted transaction moves from the input register into the result register, where it
// waits for the sink; while the result register is stalled, the input stage holds.
// Throughput: one transaction per cycle while the sink keeps the result register drained,
// set by the player state update and the tape bit read, which is refreshed from the bank RAMs every cycle.
// Reset: arst_n clears control and player state and restores the timing registers;
// the tape memory is not cleared and needs no clearing pass.
module cassette_tape_pulse_player #(
	parameter int unsigned TAPE_BITS = ctpp_pkg::TAPE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ctpp_item_if.sink                   item,
	ctpp_result_if.source               result,
	input  logic                        cfg_wr_en,
	input  ctpp_pkg::ctpp_cfg_idx_t     cfg_index,
	input  logic [ctpp_pkg::CFG_W-1:0]  cfg_data
);
	import ctpp_pkg::*;

	localparam int LEN_W = $clog2(TAPE_BITS + 1);
	localparam int POS_W = $clog2(TAPE_BITS);
	localparam logic [LEN_W-1:0]   TAPE_LEN = LEN_W'(TAPE_BITS);
	localparam logic [LEN_W+3:0]   TAPE_LEN_X = (LEN_W+4)'(TAPE_BITS);

	// Pulse phase of the player
	typedef enum logic [2:0] {
		PH_RECOVER,
		PH_READY,
		PH_IDLE,
		PH_BIT0,
		PH_BIT1
	} phase_t;

	// Timing registers
	logic [CFG_W-1:0]   low_time_q;
	logic [CFG_W-1:0]   base_time_q;
	logic [CFG_W-1:0]   one_extra_q;
	logic [CFG_W-1:0]   timeout_q;

	// Input stage
	logic               valid_s1;
	ctpp_op_t           op_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [7:0]         byte_s1;

	// Player state
	phase_t             phase_q;
	logic [LEN_W-1:0]   len_q;
	logic [POS_W-1:0]   pos_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] rise_q;
	logic [STAMP_W-1:0] fall_q;

	// Result register
	logic               out_valid_q;
	logic               level_q;
	logic               full_q;
	logic [COUNT_W-1:0] stored_q;

	// Next-state values
	phase_t             phase_d;
	logic [LEN_W-1:0]   len_d;
	logic [POS_W-1:0]   pos_d;
	logic [STAMP_W-1:0] rise_d;
	logic [STAMP_W-1:0] fall_d;
	logic               level_d;
	logic               full_d;

	logic               advance;
	logic               head_bit;
	ctpp_push_t         push;
	logic [POS_W-1:0]   rd_pos;

	logic [STAMP_W-1:0] gap;
	logic [STAMP_W-1:0] to_rise;
	logic [STAMP_W-1:0] to_fall;
	logic               timed_out;
	logic               fetch;
	logic [LEN_W-1:0]   pos_inc;
	logic [LEN_W+3:0]   len_plus8;

	// The stage moves forward when the result register is empty or being drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	assign result.valid       = out_valid_q;
	assign result.tape_level  = level_q;
	assign result.tape_full   = full_q;
	assign result.bits_stored = stored_q;

	always_comb begin
		gap       = stamp_s1 - last_q;
		to_rise   = stamp_s1 - rise_q;
		to_fall   = stamp_s1 - fall_q;
		timed_out = gap > STAMP_W'(timeout_q);
		fetch     = !timed_out && (len_q != '0) &&
			((phase_q == PH_READY) || (phase_q == PH_IDLE));
		pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
		len_plus8 = (LEN_W+4)'(len_q) + (LEN_W+4)'(8);

		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		rise_d  = rise_q;
		fall_d  = fall_q;
		level_d = 1'b0;
		full_d  = 1'b0;

		case (op_s1)
			OP_SAMPLE: begin
				if (timed_out) begin
					phase_d = PH_RECOVER;
					rise_d  = '0;
				end else if (phase_q == PH_RECOVER) begin
					phase_d = PH_READY;
				end else if (fetch) begin
					phase_d = head_bit ? PH_BIT1 : PH_BIT0;
					rise_d  = stamp_s1 + STAMP_W'(low_time_q);
					fall_d  = stamp_s1 + STAMP_W'(base_time_q) +
						(head_bit ? STAMP_W'(one_extra_q) : '0);
					pos_d   = (pos_inc >= len_q) ? '0 : POS_W'(pos_inc);
				end

				if (fetch) begin
					// Fresh pulse: distances to rise and fall are minus the timing terms,
					// and the pulse never ends on its own start sample
					level_d = (low_time_q == '0) &&
						((base_time_q != '0) || (head_bit && (one_extra_q != '0)));
				end else begin
					if ((phase_d == PH_BIT0) || (phase_d == PH_BIT1)) begin
						level_d = !to_rise[STAMP_W-1] && to_fall[STAMP_W-1];
					end
					// Past the fall stamp: drop back to idle
					if ((to_fall != '0) && !to_fall[STAMP_W-1]) begin
						phase_d = PH_IDLE;
					end
				end
			end
			OP_BIT: begin
				if (len_q >= TAPE_LEN) begin
					full_d = 1'b1;
				end else begin
					len_d = len_q + LEN_W'(1);
				end
			end
			OP_BYTE: begin
				// Keep the leading bits that fit, flag the rest as dropped
				if (len_plus8 > TAPE_LEN_X) begin
					full_d = 1'b1;
					len_d  = TAPE_LEN;
				end else begin
					len_d = LEN_W'(len_plus8);
				end
			end
			OP_CLEAR: begin
				len_d = '0;
				pos_d = '0;
			end
			default: begin
				len_d = len_q;
			end
		endcase
	end

	assign push.push_bit  = advance && (op_s1 == OP_BIT);
	assign push.push_byte = advance && (op_s1 == OP_BYTE);

	// Read the bit at the play position the state will hold after this edge
	assign rd_pos = advance ? pos_d : pos_q;

	ctpp_tape_store #(.TAPE_BITS(TAPE_BITS)) u_store (
		.clk     (clk),
		.push    (push),
		.wr_base (len_q),
		.wr_byte (byte_s1),
		.rd_pos  (rd_pos),
		.rd_bit  (head_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_time_q  <= LOW_TIME_RST;
			base_time_q <= BASE_TIME_RST;
			one_extra_q <= ONE_EXTRA_RST;
			timeout_q   <= TIMEOUT_RST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			len_q       <= '0;
			pos_q       <= '0;
			last_q      <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_LOW_TIME:  low_time_q  <= cfg_data;
					CFG_BASE_TIME: base_time_q <= cfg_data;
					CFG_ONE_EXTRA: one_extra_q <= cfg_data;
					CFG_TIMEOUT:   timeout_q   <= cfg_data;
					default:       timeout_q   <= timeout_q;
				endcase
			end

			// Hold the input stage while the result side is stalled
			if (item.ready) begin
				valid_s1 <= item.valid;
			end

			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				len_q       <= len_d;
				pos_q       <= pos_d;
				rise_q      <= rise_d;
				fall_q      <= fall_d;
				if (op_s1 == OP_SAMPLE) begin
					last_q <= stamp_s1;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1    <= item.opcode;
			stamp_s1 <= item.cycle_stamp;
			byte_s1  <= item.data_byte;
		end
		if (advance) begin
			level_q  <= level_d;
			full_q   <= full_d;
			stored_q <= COUNT_W'(len_d);
		end
	end

`ifndef SYNTH
	// Play position is zero on an empty tape and below the tape length otherwise
	a_pos_in_tape: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) |-> (pos_q == '0))
		else $error("play position set on an empty tape");

	a_pos_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) |-> (LEN_W'(pos_q) < len_q))
		else $error("play position beyond tape length");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= TAPE_LEN)
		else $error("tape length above capacity");

	// An empty result register never blocks the input side
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> item.ready)
		else $error("input stalled with an empty result register");
`endif
endmodule

// ----- rtl/ctpp_tape_bank.sv -----
module ctpp_tape_bank #(
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     rdata
);
	logic mem [DEPTH];

	// Write-first: a read of the row written in the same cycle sees the new bit
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/ctpp_tape_store.sv -----
module ctpp_tape_store #(
	parameter int unsigned TAPE_BITS = ctpp_pkg::TAPE_BITS_DEF
) (
	input  logic                                clk,
	input  ctpp_pkg::ctpp_push_t                push,
	input  logic [$clog2(TAPE_BITS+1)-1:0]      wr_base,
	input  logic [7:0]                          wr_byte,
	input  logic [$clog2(TAPE_BITS)-1:0]        rd_pos,
	output logic                                rd_bit
);
	import ctpp_pkg::*;

	localparam int unsigned ROWS  = (TAPE_BITS + 7) / 8;
	localparam int          ROW_W = $clog2(ROWS);
	localparam int          IDX_W = $clog2(TAPE_BITS + 8);

	logic [ROW_W-1:0] rd_row;
	logic [2:0]       rd_sel_q;
	logic [7:0]       bank_rdata;

	assign rd_row = ROW_W'(rd_pos >> 3);

	// Bit i of the tape lives in bank i mod 8, row i / 8
	for (genvar k = 0; k < 8; k++) begin : g_bank
		logic [2:0]       ofs;
		logic [IDX_W-1:0] idx;
		logic             fits;
		logic             we;
		logic             wdata;

		always_comb begin
			ofs   = 3'(k) - wr_base[2:0];
			idx   = IDX_W'(wr_base) + IDX_W'(ofs);
			fits  = idx < IDX_W'(TAPE_BITS);
			we    = fits && (push.push_byte || (push.push_bit && (ofs == 3'd0)));
			wdata = push.push_byte ? wr_byte[3'd7 - ofs] : wr_byte[0];
		end

		ctpp_tape_bank #(.DEPTH(ROWS)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (ROW_W'(idx >> 3)),
			.wdata (wdata),
			.raddr (rd_row),
			.rdata (bank_rdata[k])
		);
	end

	always_ff @(posedge clk) begin
		rd_sel_q <= rd_pos[2:0];
	end

	assign rd_bit = bank_rdata[rd_sel_q];
endmodule
